>>> sv/lcar_pkg.sv
// Shared constants, codes and types for the load cell ADC reader.
package lcar_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int MAX_AVERAGE = 255;
   localparam int CNT_W       = 8;
   localparam int ACC_W       = SAMPLE_BITS + CNT_W;
   localparam int BIT_W       = $clog2(SAMPLE_BITS + 1);
   localparam int TICK_W      = 16;
   localparam int OFFSET_W    = 25;
   localparam int NET_W       = 26;
   localparam int AVG_W       = 24;
   localparam int PULSE_W     = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [1:0] OP_TICK        = 2'd0;
   localparam logic [1:0] OP_MEASURE     = 2'd1;
   localparam logic [1:0] OP_TARE        = 2'd2;
   localparam logic [1:0] OP_LOAD_OFFSET = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_EXTRA_PULSES  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AVERAGE_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_PERIOD   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_POWER_DOWN    = 2'd3;

   typedef struct packed {
      logic [PULSE_W-1:0] extra_pulses;
      logic [CNT_W-1:0]   average_count;
      logic [TICK_W-1:0]  half_period_ticks;
      logic               power_down;
   } cfg_type;

   // one queued tick, with its opcode already decoded
   typedef struct packed {
      logic                       dout;
      logic                       starts;
      logic                       is_tare;
      logic                       loads;
      logic signed [OFFSET_W-1:0] new_offset;
   } item_type;

   typedef struct packed {
      logic                    start;
      logic signed [ACC_W-1:0] dividend;
      logic [CNT_W-1:0]        divisor;
   } div_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [ACC_W-1:0] quotient;
   } div_rsp_type;

endpackage

>>> sv/lcar_front.sv
// Input side: accepts ticks, decodes the opcode and queues them for the sequencer.
module lcar_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_dout,
   input  logic [1:0]                          req_opcode,
   input  logic signed [lcar_pkg::OFFSET_W-1:0] req_new_offset,
   output logic                                head_valid,
   output lcar_pkg::item_type                  head,
   input  logic                                pop
);
   import lcar_pkg::*;

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);

   item_type           queue_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;
   logic               push;
   item_type           decoded;

   assign req_ready  = (count_ff != (PTR_W+1)'(DEPTH));
   assign push       = req_valid & req_ready;
   assign head_valid = (count_ff != '0);
   assign head       = queue_ff[rd_ptr_ff];

   always_comb begin
      decoded.dout       = req_dout;
      decoded.starts     = (req_opcode == OP_MEASURE) || (req_opcode == OP_TARE);
      decoded.is_tare    = (req_opcode == OP_TARE);
      decoded.loads      = (req_opcode == OP_LOAD_OFFSET);
      decoded.new_offset = req_new_offset;
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

>>> sv/lcar_div.sv
// Signed by unsigned divider, one quotient bit per cycle, truncating toward zero.
module lcar_div (
   input  logic                 clock,
   input  logic                 reset,
   input  lcar_pkg::div_req_type div_req,
   output lcar_pkg::div_rsp_type div_rsp
);
   import lcar_pkg::*;

   localparam logic [1:0] DV_IDLE = 2'd0;
   localparam logic [1:0] DV_RUN  = 2'd1;
   localparam logic [1:0] DV_DONE = 2'd2;
   localparam int STEP_W = $clog2(ACC_W + 1);

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [ACC_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  divisor_ff, divisor_in;
   logic              neg_ff, neg_in;
   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    diff;
   logic              fits;

   always_comb begin
      trial = {rem_ff, quo_ff[ACC_W-1]};
      diff  = trial - {1'b0, divisor_ff};
      fits  = (trial >= {1'b0, divisor_ff});

      state_in   = state_ff;
      step_in    = step_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      neg_in     = neg_ff;

      if (div_req.start) begin
         state_in   = DV_RUN;
         step_in    = STEP_W'(ACC_W);
         neg_in     = div_req.dividend[ACC_W-1];
         quo_in     = div_req.dividend[ACC_W-1] ? unsigned'(-div_req.dividend)
                                                : unsigned'(div_req.dividend);
         rem_in     = '0;
         divisor_in = div_req.divisor;
      end else if (state_ff == DV_RUN) begin
         rem_in  = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         quo_in  = {quo_ff[ACC_W-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            state_in = DV_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      neg_ff     <= neg_in;
   end

   assign div_rsp.done     = (state_ff == DV_DONE);
   assign div_rsp.quotient = neg_ff ? -signed'(quo_ff) : signed'(quo_ff);

endmodule

>>> sv/lcar_back.sv
// Sequencer: SCK phase timing, bit capture, averaging and the result register.
module lcar_back (
   input  logic                                    clock,
   input  logic                                    reset,
   input  lcar_pkg::cfg_type                       cfg,
   input  logic                                    head_valid,
   input  lcar_pkg::item_type                      head,
   output logic                                    pop,
   output lcar_pkg::div_req_type                   div_req,
   input  lcar_pkg::div_rsp_type                   div_rsp,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic                                    rsp_sck,
   output logic                                    rsp_busy_res,
   output logic                                    rsp_result_valid,
   output logic                                    rsp_was_tare,
   output logic signed [lcar_pkg::NET_W-1:0]       rsp_net_value,
   output logic signed [lcar_pkg::AVG_W-1:0]       rsp_raw_average
);
   import lcar_pkg::*;

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_WAIT  = 3'd1;
   localparam logic [2:0] PH_DHIGH = 3'd2;
   localparam logic [2:0] PH_DLOW  = 3'd3;
   localparam logic [2:0] PH_GHIGH = 3'd4;
   localparam logic [2:0] PH_GLOW  = 3'd5;

   logic [2:0]                 phase_ff, phase_in;
   logic [BIT_W-1:0]           bit_cnt_ff, bit_cnt_in;
   logic [TICK_W-1:0]          tick_cnt_ff, tick_cnt_in;
   logic [SAMPLE_BITS-1:0]     shift_ff, shift_in;
   logic [CNT_W-1:0]           read_cnt_ff, read_cnt_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [OFFSET_W-1:0] offset_ff, offset_in;
   logic                       tare_ff, tare_in;
   logic                       wait_div_ff, wait_div_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       sck_ff, sck_in;
   logic                       busy_ff, busy_in;
   logic                       res_valid_ff, res_valid_in;
   logic                       was_tare_ff, was_tare_in;
   logic signed [NET_W-1:0]    net_ff, net_in;
   logic signed [AVG_W-1:0]    avg_ff, avg_in;

   logic [TICK_W-1:0]          hp;
   logic [PULSE_W-1:0]         pulses;
   logic [CNT_W-1:0]           cnt;
   logic                       slot_free;
   logic                       complete;
   logic                       emit;
   logic [BIT_W-1:0]           bit_inc;
   logic [CNT_W-1:0]           read_inc;
   logic signed [AVG_W-1:0]    avg;

   always_comb begin
      hp     = (cfg.half_period_ticks == '0) ? TICK_W'(1) : cfg.half_period_ticks;
      pulses = (cfg.extra_pulses == '0) ? PULSE_W'(1) : cfg.extra_pulses;
      cnt    = (cfg.average_count == '0) ? CNT_W'(1) : cfg.average_count;
      if (cnt > CNT_W'(MAX_AVERAGE)) begin
         cnt = CNT_W'(MAX_AVERAGE);
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign pop       = head_valid && !wait_div_ff && slot_free;
   assign emit      = wait_div_ff && div_rsp.done && slot_free;
   assign bit_inc   = bit_cnt_ff + 1'b1;
   assign read_inc  = read_cnt_ff + 1'b1;
   assign avg       = div_rsp.quotient[AVG_W-1:0];

   // one tick of the serial sequencer
   always_comb begin
      phase_in    = phase_ff;
      bit_cnt_in  = bit_cnt_ff;
      tick_cnt_in = tick_cnt_ff;
      shift_in    = shift_ff;
      read_cnt_in = read_cnt_ff;
      acc_in      = acc_ff;
      offset_in   = offset_ff;
      tare_in     = tare_ff;
      complete    = 1'b0;

      unique case (phase_ff)
         PH_IDLE: begin
            if (head.starts) begin
               tare_in     = head.is_tare;
               read_cnt_in = '0;
               acc_in      = '0;
               bit_cnt_in  = '0;
               shift_in    = '0;
               tick_cnt_in = '0;
               phase_in    = PH_WAIT;
            end else if (head.loads) begin
               offset_in = head.new_offset;
            end
         end
         PH_WAIT: begin
            if (!head.dout) begin
               bit_cnt_in  = '0;
               shift_in    = '0;
               tick_cnt_in = TICK_W'(1);
               phase_in    = PH_DHIGH;
            end
         end
         PH_DHIGH, PH_DLOW, PH_GHIGH, PH_GLOW: begin
            priority if (tick_cnt_ff < hp) begin
               tick_cnt_in = tick_cnt_ff + 1'b1;
            end else if (phase_ff == PH_DHIGH) begin
               shift_in    = {shift_ff[SAMPLE_BITS-2:0], head.dout};
               tick_cnt_in = TICK_W'(1);
               phase_in    = PH_DLOW;
            end else if (phase_ff == PH_DLOW) begin
               tick_cnt_in = TICK_W'(1);
               if (bit_inc >= BIT_W'(SAMPLE_BITS)) begin
                  bit_cnt_in = '0;
                  phase_in   = PH_GHIGH;
               end else begin
                  bit_cnt_in = bit_inc;
                  phase_in   = PH_DHIGH;
               end
            end else if (phase_ff == PH_GHIGH) begin
               tick_cnt_in = TICK_W'(1);
               phase_in    = PH_GLOW;
            end else begin
               if (bit_inc < BIT_W'(pulses)) begin
                  bit_cnt_in  = bit_inc;
                  tick_cnt_in = TICK_W'(1);
                  phase_in    = PH_GHIGH;
               end else begin
                  bit_cnt_in  = '0;
                  tick_cnt_in = '0;
                  acc_in      = acc_ff + ACC_W'(signed'(shift_ff));
                  if (read_inc >= cnt) begin
                     read_cnt_in = '0;
                     complete    = 1'b1;
                     phase_in    = PH_IDLE;
                  end else begin
                     read_cnt_in = read_inc;
                     phase_in    = PH_WAIT;
                  end
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_comb begin
      div_req.start    = pop && complete;
      div_req.dividend = acc_in;
      div_req.divisor  = cnt;
   end

   always_comb begin
      wait_div_in  = wait_div_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      sck_in       = sck_ff;
      busy_in      = busy_ff;
      res_valid_in = res_valid_ff;
      was_tare_in  = was_tare_ff;
      net_in       = net_ff;
      avg_in       = avg_ff;

      if (emit) begin
         // averaging done: the block is already back to idle
         wait_div_in  = 1'b0;
         rsp_valid_in = 1'b1;
         sck_in       = cfg.power_down;
         busy_in      = 1'b0;
         res_valid_in = 1'b1;
         was_tare_in  = tare_ff;
         avg_in       = avg;
         net_in       = tare_ff ? '0 : NET_W'(avg) - NET_W'(offset_ff);
      end else if (pop && complete) begin
         wait_div_in = 1'b1;
      end else if (pop) begin
         rsp_valid_in = 1'b1;
         sck_in       = (phase_in == PH_IDLE) ? cfg.power_down
                      : ((phase_in == PH_DHIGH) || (phase_in == PH_GHIGH));
         busy_in      = (phase_in != PH_IDLE);
         res_valid_in = 1'b0;
         was_tare_in  = 1'b0;
         net_in       = '0;
         avg_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bit_cnt_ff   <= '0;
         tick_cnt_ff  <= '0;
         shift_ff     <= '0;
         read_cnt_ff  <= '0;
         acc_ff       <= '0;
         offset_ff    <= '0;
         tare_ff      <= 1'b0;
         wait_div_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff    <= phase_in;
            bit_cnt_ff  <= bit_cnt_in;
            tick_cnt_ff <= tick_cnt_in;
            shift_ff    <= shift_in;
            read_cnt_ff <= read_cnt_in;
            acc_ff      <= acc_in;
            offset_ff   <= offset_in;
            tare_ff     <= tare_in;
         end else if (emit && tare_ff) begin
            offset_ff <= OFFSET_W'(avg);
         end
         wait_div_ff  <= wait_div_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sck_ff       <= sck_in;
      busy_ff      <= busy_in;
      res_valid_ff <= res_valid_in;
      was_tare_ff  <= was_tare_in;
      net_ff       <= net_in;
      avg_ff       <= avg_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sck          = sck_ff;
   assign rsp_busy_res     = busy_ff;
   assign rsp_result_valid = res_valid_ff;
   assign rsp_was_tare     = was_tare_ff;
   assign rsp_net_value    = net_ff;
   assign rsp_raw_average  = avg_ff;

`ifndef SYNTHESIS
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && res_valid_ff |-> !busy_ff)
      else $error("completed item still shows busy");

   a_no_pop_while_dividing: assert property (@(posedge clock) disable iff (reset)
      wait_div_ff |-> !pop)
      else $error("item taken while the average is pending");

   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !res_valid_ff |-> !was_tare_ff && net_ff == '0 && avg_ff == '0)
      else $error("result fields nonzero without a result");

   a_divide_waits_idle: assert property (@(posedge clock) disable iff (reset)
      wait_div_ff |-> phase_ff == PH_IDLE && read_cnt_ff == '0)
      else $error("sequencer not idle while averaging");
`endif

endmodule

>>> sv/load_cell_adc_reader_top.sv
// Top level of the load cell ADC reader: register file and the three units.
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_ready  req_dout, req_opcode, req_new_offset
//   rsp      out  rsp_valid/rsp_ready  rsp_sck, rsp_busy_res, rsp_result_valid,
//                                      rsp_was_tare, rsp_net_value, rsp_raw_average
//   csr      in   csr_valid/csr_ready  csr_index, csr_wdata
//
// Every item returns one item. Items take one cycle each, except the one that
// closes the last reading, which holds the sequencer while the bit-serial
// divider runs. A two-entry queue sits between input and sequencer; a result
// waiting in the output register stalls the sequencer, and the queue then fills
// and drops req_ready. Synchronous reset brings the configuration and control
// state to their reset values and empties the queue; csr is always ready.
module load_cell_adc_reader_top (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic                                      req_dout,
   input  logic [1:0]                                req_opcode,
   input  logic signed [lcar_pkg::OFFSET_W-1:0]      req_new_offset,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic                                      rsp_sck,
   output logic                                      rsp_busy_res,
   output logic                                      rsp_result_valid,
   output logic                                      rsp_was_tare,
   output logic signed [lcar_pkg::NET_W-1:0]         rsp_net_value,
   output logic signed [lcar_pkg::AVG_W-1:0]         rsp_raw_average,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [lcar_pkg::CSR_IDX_W-1:0]            csr_index,
   input  logic [lcar_pkg::CSR_DATA_W-1:0]           csr_wdata
);
   import lcar_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   logic        head_valid;
   item_type    head;
   logic        pop;
   div_req_type div_req;
   div_rsp_type div_rsp;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_EXTRA_PULSES:  cfg_in.extra_pulses      = csr_wdata[PULSE_W-1:0];
            CSR_AVERAGE_COUNT: cfg_in.average_count     = csr_wdata[CNT_W-1:0];
            CSR_HALF_PERIOD:   cfg_in.half_period_ticks = csr_wdata[TICK_W-1:0];
            CSR_POWER_DOWN:    cfg_in.power_down        = csr_wdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.extra_pulses      <= PULSE_W'(1);
         cfg_ff.average_count     <= CNT_W'(1);
         cfg_ff.half_period_ticks <= TICK_W'(100);
         cfg_ff.power_down        <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lcar_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_dout       (req_dout),
      .req_opcode     (req_opcode),
      .req_new_offset (req_new_offset),
      .head_valid     (head_valid),
      .head           (head),
      .pop            (pop)
   );

   lcar_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   lcar_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .head_valid       (head_valid),
      .head             (head),
      .pop              (pop),
      .div_req          (div_req),
      .div_rsp          (div_rsp),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sck          (rsp_sck),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_result_valid (rsp_result_valid),
      .rsp_was_tare     (rsp_was_tare),
      .rsp_net_value    (rsp_net_value),
      .rsp_raw_average  (rsp_raw_average)
   );

endmodule
